@@ design/humidity_temp_frame_decoder_unit_defines.svh @@
// Assertion helpers shared by the decoder modules.
// Each expects i_clk and i_rst_n in the enclosing module.
`ifndef HUMIDITY_TEMP_FRAME_DECODER_UNIT_DEFINES_SVH
`define HUMIDITY_TEMP_FRAME_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define HTFD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("htfd: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HTFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("htfd: next-cycle check failed");

`endif

@@ design/htfd_pkg.sv @@
`timescale 1ns / 1ps

package htfd_pkg;

    localparam logic [7:0]  CRC_POLY    = 8'h31;
    localparam logic [7:0]  CRC_INIT    = 8'hFF;
    localparam logic [14:0] TEMP_SPAN   = 15'd17500;
    localparam logic [14:0] HUM_SPAN    = 15'd10000;
    localparam logic [14:0] TEMP_OFFSET = 15'd4500;

    // Byte positions inside one frame
    localparam logic [2:0] POS_T_MSB = 3'd0;
    localparam logic [2:0] POS_T_LSB = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_MSB = 3'd3;
    localparam logic [2:0] POS_H_LSB = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // Item passed from the frame tracker to the converter
    typedef struct packed {
        logic        emit;     // humidity check byte: produce a result
        logic        good;     // CRC of this word matched
        logic [30:0] prod;     // span * masked raw word
        logic        temp_ok;
        logic [15:0] raw_t;
        logic [15:0] raw_h;
    } t_conv_item;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

@@ design/htfd_if.sv @@
`timescale 1ns / 1ps

interface htfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, rx_byte, frame_start, input ready);
    modport sink (input valid, rx_byte, frame_start, output ready);
endinterface

interface htfd_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] temperature_centi;
    logic [13:0]        humidity_centi;
    logic               temperature_ok;
    logic               humidity_ok;
    logic [15:0]        raw_temperature;
    logic [15:0]        raw_humidity;

    modport source (output valid, temperature_centi, humidity_centi, temperature_ok,
                    humidity_ok, raw_temperature, raw_humidity, input ready);
    modport sink (input valid, temperature_centi, humidity_centi, temperature_ok,
                  humidity_ok, raw_temperature, raw_humidity, output ready);
endinterface

@@ design/humidity_temp_frame_decoder_unit.sv @@
`timescale 1ns / 1ps
// Humidity/temperature sensor frame decoder.
// Input channel i_in carries one frame byte per item (rx_byte) and a
// frame_start flag that forces the byte to be taken as a temperature MSB.
// A frame is temperature MSB, LSB, CRC, then humidity MSB, LSB, CRC; each
// word is checked with CRC-8 (poly 0x31, init 0xFF). A matching word updates
// the held value in hundredths of a degree or of a percent.
// Output channel o_out carries one result per sixth byte: held values, the
// two CRC flags and both raw words of the frame.
// Throughput: one byte per cycle unless a result waits behind a stalled o_out;
// set by the combinational CRC step and the shared constant multiplier. A result
// passes the multiply register, then the divide-and-output register, after the
// edge that accepts the sixth byte.
// When o_out stalls, the result holds in the output register while frame
// bytes keep flowing through the multiply stage; input stalls only once the
// next sixth byte sits in the multiply register behind the waiting result.
// Reset (synchronous, active low) clears the byte position, sets the CRC to
// 0xFF, clears the held values and empties both stages.
module humidity_temp_frame_decoder_unit
    import htfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    htfd_in_if.sink    i_in,
    htfd_out_if.source o_out
);

    logic       a_valid;
    logic       a_ready;
    t_conv_item a_item;

    htfd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_a_ready (a_ready),
        .o_a_valid (a_valid),
        .o_a       (a_item)
    );

    htfd_conv u_conv (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_a_valid (a_valid),
        .i_a       (a_item),
        .o_a_ready (a_ready),
        .o_out     (o_out)
    );

endmodule

@@ design/htfd_front.sv @@
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_unit_defines.svh"

module htfd_front
    import htfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    htfd_in_if.sink    i_in,
    input  logic       i_a_ready,
    output logic       o_a_valid,
    output t_conv_item o_a
);

    logic [2:0]  r_pos, n_pos;
    logic [7:0]  r_crc, n_crc;
    logic [15:0] r_word, n_word;
    logic [15:0] r_tword, n_tword;
    logic        r_tgood, n_tgood;
    logic        r_a_valid;
    t_conv_item  r_a, n_a;

    logic        accept;
    logic [2:0]  pos_eff;
    logic        good;
    logic [14:0] scale;
    logic [15:0] masked;

    assign i_in.ready = i_a_ready;
    assign accept     = i_in.valid && i_a_ready;
    assign good       = (r_crc == i_in.rx_byte);

    always_comb begin
        if (i_in.frame_start || r_pos > POS_H_CRC) begin
            pos_eff = POS_T_MSB;
        end else begin
            pos_eff = r_pos;
        end
    end

    // One shared constant multiplier; the word buffer is stable at check bytes
    assign scale  = (pos_eff == POS_T_CRC) ? TEMP_SPAN : HUM_SPAN;
    assign masked = {r_word[15:2], 2'b00};

    always_comb begin
        n_pos   = r_pos;
        n_crc   = r_crc;
        n_word  = r_word;
        n_tword = r_tword;
        n_tgood = r_tgood;
        n_a.emit    = 1'b0;
        n_a.good    = good;
        n_a.prod    = 31'(scale) * 31'(masked);
        n_a.temp_ok = r_tgood;
        n_a.raw_t   = r_tword;
        n_a.raw_h   = r_word;
        case (pos_eff)
            POS_T_MSB, POS_H_MSB: begin
                n_crc  = crc8_byte(CRC_INIT, i_in.rx_byte);
                n_word = {i_in.rx_byte, 8'h00};
                n_pos  = pos_eff + 3'd1;
                n_a.good = 1'b0;
            end
            POS_T_LSB, POS_H_LSB: begin
                n_crc  = crc8_byte(r_crc, i_in.rx_byte);
                n_word = {r_word[15:8], i_in.rx_byte};
                n_pos  = pos_eff + 3'd1;
                n_a.good = 1'b0;
            end
            POS_T_CRC: begin
                n_tgood = good;
                n_tword = r_word;
                n_crc   = CRC_INIT;
                n_pos   = POS_H_MSB;
            end
            default: begin
                n_crc    = CRC_INIT;
                n_pos    = POS_T_MSB;
                n_a.emit = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= POS_T_MSB;
            r_crc     <= CRC_INIT;
            r_word    <= '0;
            r_tword   <= '0;
            r_tgood   <= 1'b0;
            r_a_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_pos   <= n_pos;
                r_crc   <= n_crc;
                r_word  <= n_word;
                r_tword <= n_tword;
                r_tgood <= n_tgood;
            end
            if (i_a_ready) begin
                r_a_valid <= accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a <= n_a;
        end
    end

    assign o_a_valid = r_a_valid;
    assign o_a       = r_a;

    `HTFD_ASSERT_NOW(a_pos_range, 1'b1, r_pos <= POS_H_CRC)
    `HTFD_ASSERT_NEXT(a_start_pos, accept && i_in.frame_start, r_pos == POS_T_LSB)
    `HTFD_ASSERT_NOW(a_emit_pos, r_a_valid && r_a.emit, r_pos == POS_T_MSB && r_crc == CRC_INIT)

endmodule

@@ design/htfd_conv.sv @@
`timescale 1ns / 1ps
`include "humidity_temp_frame_decoder_unit_defines.svh"

module htfd_conv
    import htfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_a_valid,
    input  t_conv_item i_a,
    output logic       o_a_ready,
    htfd_out_if.source o_out
);

    logic signed [14:0] r_held_t;
    logic [13:0]        r_held_h;
    logic               r_out_valid;
    logic signed [14:0] r_temp;
    logic [13:0]        r_hum;
    logic               r_tok;
    logic               r_hok;
    logic [15:0]        r_raw_t;
    logic [15:0]        r_raw_h;

    logic               out_free;
    logic               take;
    logic [31:0]        sum;
    logic [15:0]        quot;
    logic [14:0]        tdiff;
    logic signed [14:0] tconv;
    logic [13:0]        hconv;
    logic [13:0]        n_hum;

    assign out_free  = !r_out_valid || o_out.ready;
    assign o_a_ready = !i_a_valid || !i_a.emit || out_free;
    assign take      = i_a_valid && o_a_ready;

    // floor(p / 65535) = (p + (p >> 16) + 1) >> 16 for p below 2^31
    assign sum   = {1'b0, i_a.prod} + {17'd0, i_a.prod[30:16]} + 32'd1;
    assign quot  = sum[31:16];
    assign tdiff = quot[14:0] - TEMP_OFFSET;
    assign tconv = $signed(tdiff);
    assign hconv = quot[13:0];
    assign n_hum = i_a.good ? hconv : r_held_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_t    <= '0;
            r_held_h    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take && !i_a.emit && i_a.good) begin
                r_held_t <= tconv;
            end
            if (take && i_a.emit) begin
                r_held_h <= n_hum;
            end
            if (out_free) begin
                r_out_valid <= take && i_a.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_a.emit) begin
            r_temp  <= r_held_t;
            r_hum   <= n_hum;
            r_tok   <= i_a.temp_ok;
            r_hok   <= i_a.good;
            r_raw_t <= i_a.raw_t;
            r_raw_h <= i_a.raw_h;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.temperature_centi = r_temp;
    assign o_out.humidity_centi    = r_hum;
    assign o_out.temperature_ok    = r_tok;
    assign o_out.humidity_ok       = r_hok;
    assign o_out.raw_temperature   = r_raw_t;
    assign o_out.raw_humidity      = r_raw_h;

    `HTFD_ASSERT_NOW(a_hum_range, 1'b1, r_held_h <= 14'd9999)
    `HTFD_ASSERT_NOW(a_temp_range, 1'b1, r_held_t >= -15'sd4500 && r_held_t <= 15'sd12999)
    `HTFD_ASSERT_NOW(a_stall_cause, i_a_valid && !o_a_ready, r_out_valid && !o_out.ready)

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import htfd_pkg::*;

    localparam int          ITEM_TARGET  = 950;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 8;
    localparam logic [15:0] STATUS_BITS  = 16'h0003;
    localparam logic [31:0] FULL_SCALE   = 32'd65535;

    typedef struct packed {
        logic signed [14:0] temperature;
        logic [13:0]        humidity;
        logic               temp_ok;
        logic               hum_ok;
        logic [15:0]        raw_temp;
        logic [15:0]        raw_hum;
    } sensor_reading_t;

    class reading_scoreboard;
        sensor_reading_t    pending_readings[$];
        int unsigned        mismatches;
        int unsigned        readings_checked;
        int unsigned        temp_rejects;
        int unsigned        hum_rejects;
        logic [2:0]         frame_pos;
        logic [7:0]         crc_acc;
        logic [15:0]        word_acc;
        logic [15:0]        temp_word;
        logic               temp_good;
        logic signed [14:0] held_temp;
        logic [13:0]        held_hum;

        function new();
            mismatches = 0;
            readings_checked = 0;
            temp_rejects = 0;
            hum_rejects = 0;
            frame_pos = POS_T_MSB;
            crc_acc = CRC_INIT;
            word_acc = '0;
            temp_word = '0;
            temp_good = 1'b0;
            held_temp = '0;
            held_hum = '0;
        endfunction

        // Bit-serial form: feed the byte MSB first through the feedback tap.
        static function logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
            logic [7:0] c;
            logic       fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[7] ^ b[i];
                c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return c;
        endfunction

        static function logic [7:0] word_crc(input logic [15:0] w);
            return crc_step(crc_step(CRC_INIT, w[15:8]), w[7:0]);
        endfunction

        static function logic signed [14:0] centi_degrees(input logic [15:0] raw);
            logic [31:0] q;
            q = ({17'd0, TEMP_SPAN} * {16'd0, raw & ~STATUS_BITS}) / FULL_SCALE;
            return 15'(q - {17'd0, TEMP_OFFSET});
        endfunction

        static function logic [13:0] centi_percent(input logic [15:0] raw);
            logic [31:0] q;
            q = ({17'd0, HUM_SPAN} * {16'd0, raw & ~STATUS_BITS}) / FULL_SCALE;
            return 14'(q);
        endfunction

        function void note_byte(input logic [7:0] b, input logic fs);
            logic [2:0]      pos;
            logic            match;
            sensor_reading_t r;
            pos = fs ? POS_T_MSB : frame_pos;
            case (pos)
                POS_T_LSB, POS_H_LSB: begin
                    crc_acc = crc_step(crc_acc, b);
                    word_acc[7:0] = b;
                    frame_pos = pos + 3'd1;
                end
                POS_T_CRC: begin
                    match = (crc_acc == b);
                    temp_good = match;
                    temp_word = word_acc;
                    if (match) held_temp = centi_degrees(word_acc);
                    else temp_rejects++;
                    crc_acc = CRC_INIT;
                    frame_pos = POS_H_MSB;
                end
                POS_H_MSB: begin
                    crc_acc = crc_step(CRC_INIT, b);
                    word_acc = {b, 8'h00};
                    frame_pos = POS_H_LSB;
                end
                POS_H_CRC: begin
                    match = (crc_acc == b);
                    if (match) held_hum = centi_percent(word_acc);
                    else hum_rejects++;
                    crc_acc = CRC_INIT;
                    frame_pos = POS_T_MSB;
                    r.temperature = held_temp;
                    r.humidity = held_hum;
                    r.temp_ok = temp_good;
                    r.hum_ok = match;
                    r.raw_temp = temp_word;
                    r.raw_hum = word_acc;
                    pending_readings.push_back(r);
                end
                // temperature MSB; the unreachable positions act the same way
                default: begin
                    crc_acc = crc_step(CRC_INIT, b);
                    word_acc = {b, 8'h00};
                    frame_pos = POS_T_LSB;
                end
            endcase
        endfunction

        task report(input string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            mismatches++;
        endtask

        task check_reading(input sensor_reading_t got);
            sensor_reading_t want;
            if (pending_readings.size() == 0) begin
                report("reading arrived with none outstanding");
                return;
            end
            want = pending_readings.pop_front();
            readings_checked++;
            if (got.temperature !== want.temperature)
                report($sformatf("temperature_centi got %0d want %0d",
                                 got.temperature, want.temperature));
            if (got.humidity !== want.humidity)
                report($sformatf("humidity_centi got %0d want %0d",
                                 got.humidity, want.humidity));
            if (got.temp_ok !== want.temp_ok)
                report($sformatf("temperature_ok got %b want %b", got.temp_ok, want.temp_ok));
            if (got.hum_ok !== want.hum_ok)
                report($sformatf("humidity_ok got %b want %b", got.hum_ok, want.hum_ok));
            if (got.raw_temp !== want.raw_temp)
                report($sformatf("raw_temperature got %h want %h", got.raw_temp, want.raw_temp));
            if (got.raw_hum !== want.raw_hum)
                report($sformatf("raw_humidity got %h want %h", got.raw_hum, want.raw_hum));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    htfd_in_if  in_if();
    htfd_out_if out_if();

    reading_scoreboard sb;
    int unsigned       bytes_sent;
    int unsigned       src_idle_pct;
    int unsigned       snk_idle_pct;
    int unsigned       cycle_count;
    bit                aligned;

    humidity_temp_frame_decoder_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Call at a falling edge; returns at the falling edge after the item is taken.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        if (bytes_sent < ITEM_TARGET / 3) begin
            src_idle_pct = 35;
            snk_idle_pct = 68;
        end else if (bytes_sent < 2 * ITEM_TARGET / 3) begin
            src_idle_pct = 68;
            snk_idle_pct = 35;
        end else begin
            src_idle_pct = 0;
            snk_idle_pct = 0;
        end
        while ($urandom_range(0, 99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            in_if.rx_byte <= 8'($urandom);
            in_if.frame_start <= 1'($urandom);
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.rx_byte <= b;
        in_if.frame_start <= fs;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        sb.note_byte(b, fs);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [15:0] t_raw, input logic t_ok,
                              input logic [15:0] h_raw, input logic h_ok,
                              input logic mark);
        logic [7:0] t_crc;
        logic [7:0] h_crc;
        t_crc = reading_scoreboard::word_crc(t_raw);
        h_crc = reading_scoreboard::word_crc(h_raw);
        // a nonzero flip guarantees the check byte misses
        if (!t_ok) t_crc ^= 8'($urandom_range(1, 255));
        if (!h_ok) h_crc ^= 8'($urandom_range(1, 255));
        send_byte(t_raw[15:8], mark);
        send_byte(t_raw[7:0], 1'b0);
        send_byte(t_crc, 1'b0);
        send_byte(h_raw[15:8], 1'b0);
        send_byte(h_raw[7:0], 1'b0);
        send_byte(h_crc, 1'b0);
    endtask

    function automatic logic [15:0] pick_word();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 8) return 16'h0000;
        if (sel < 16) return 16'hFFFF;
        if (sel < 22) return 16'($urandom_range(0, 3));
        return 16'($urandom);
    endfunction

    initial begin
        int unsigned n;
        sb = new();
        bytes_sent = 0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        i_rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.rx_byte = 8'h00;
        in_if.frame_start = 1'b0;
        out_if.ready = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // both checks fail before any good word: held values stay zero
        send_frame(16'hFFFF, 1'b0, 16'h0000, 1'b0, 1'b1);
        // back to back without a marker, full-scale extremes
        send_frame(16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b0);
        // partial frame cut off in the humidity word by a new frame start
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(reading_scoreboard::word_crc(16'h1234), 1'b0);
        send_byte(8'hA5, 1'b0);
        send_frame(16'hFFFF, 1'b1, 16'h0003, 1'b1, 1'b1);
        // good temperature with bad humidity keeps the old humidity
        send_frame(16'h6666, 1'b1, 16'h8000, 1'b0, 1'b1);

        aligned = 1'b1;
        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 85) begin
                send_frame(pick_word(), $urandom_range(0, 99) < 80,
                           pick_word(), $urandom_range(0, 99) < 80,
                           !aligned || $urandom_range(0, 1));
                aligned = 1'b1;
            end else begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'($urandom), $urandom_range(0, 99) < 25);
                aligned = 1'b0;
            end
        end
        in_if.valid <= 1'b0;

        while (sb.pending_readings.size() != 0) @(posedge i_clk);
        // catch any stray reading after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d frame bytes in %0d cycles; checked %0d readings.",
                 bytes_sent, cycle_count, sb.readings_checked);
        $display("Temperature CRC rejects: %0d, humidity CRC rejects: %0d, mismatches: %0d.",
                 sb.temp_rejects, sb.hum_rejects, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Result side: stall at random, check each taken reading.
    initial begin
        sensor_reading_t got;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.temperature = out_if.temperature_centi;
                got.humidity = out_if.humidity_centi;
                got.temp_ok = out_if.temperature_ok;
                got.hum_ok = out_if.humidity_ok;
                got.raw_temp = out_if.raw_temperature;
                got.raw_hum = out_if.raw_humidity;
                sb.check_reading(got);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles", cycle_count);
        $display("Simulation FAILED");
        $finish;
    end

endmodule
